/* rtl/btlv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV stream parser package
// Shared types and constants for the parser front end, queue and back end.
// ----------------------------------------------------------------------------
package btlv_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int TDATA_W     = 80;

    localparam logic [7:0] TAG_LONG_MASK = 8'h1f;
    localparam logic [7:0] MORE_BIT_MASK = 8'h80;
    localparam logic [7:0] SHORT_LEN_MAX = 8'd127;

    typedef enum logic [2:0] {
        PH_TAG_FIRST = 3'd0,
        PH_TAG_LONG  = 3'd1,
        PH_LEN_FIRST = 3'd2,
        PH_LEN_MORE  = 3'd3,
        PH_VALUE     = 3'd4,
        PH_ERROR     = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        KIND_TAG     = 3'd0,
        KIND_LENGTH  = 3'd1,
        KIND_VALUE   = 3'd2,
        KIND_ERROR   = 3'd3,
        KIND_IGNORED = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        END_NONE      = 2'd0,
        END_CLEAN     = 2'd1,
        END_TRUNCATED = 2'd2,
        END_ERROR     = 2'd3
    } end_status_t;

    // One input byte together with the flags the back end decodes on.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic       tag_long;
        logic       more_bit;
        logic       len_one;
        logic       len_two;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } queue_head_t;

    typedef struct packed {
        kind_t       byte_kind;
        logic [7:0]  byte_value;
        logic [15:0] decoded_length;
        logic [15:0] value_offset;
        logic        record_done;
        logic [31:0] tag_bits;
        logic [2:0]  tag_bytes;
        end_status_t end_status;
    } result_t;

endpackage

/* rtl/btlv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV front end
// Accepts input items and tags each byte with the flags that the parser
// back end needs, then writes it into the queue.
// ----------------------------------------------------------------------------
module btlv_front (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               s_axis_tlast,
    input  logic               queue_full,
    output logic               queue_push,
    output btlv_pkg::item_t    queue_item
);

    assign s_axis_tready = !queue_full;
    assign queue_push    = s_axis_tvalid && !queue_full;

    always_comb begin
        queue_item.data_byte = s_axis_tdata;
        queue_item.last_byte = s_axis_tlast;
        queue_item.tag_long  = (s_axis_tdata & btlv_pkg::TAG_LONG_MASK)
                               == btlv_pkg::TAG_LONG_MASK;
        queue_item.more_bit  = (s_axis_tdata & btlv_pkg::MORE_BIT_MASK) != 8'd0;
        queue_item.len_one   = (s_axis_tdata > btlv_pkg::SHORT_LEN_MAX) && s_axis_tdata[0];
        queue_item.len_two   = (s_axis_tdata > btlv_pkg::SHORT_LEN_MAX) && !s_axis_tdata[0]
                               && s_axis_tdata[1];
    end

endmodule

/* rtl/btlv_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV item queue
// A short first-in first-out queue that decouples the front end from the
// parser back end.
// ----------------------------------------------------------------------------
module btlv_queue (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  btlv_pkg::item_t         push_item,
    output logic                    full,
    input  logic                    pop,
    output btlv_pkg::queue_head_t   head
);

    btlv_pkg::item_t                 entries_reg [btlv_pkg::QUEUE_DEPTH];
    logic [btlv_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [btlv_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [btlv_pkg::QUEUE_AW:0]     count_reg, count_next;
    logic                            do_push, do_pop;

    assign full       = count_reg == (btlv_pkg::QUEUE_AW+1)'(btlv_pkg::QUEUE_DEPTH);
    assign head.valid = count_reg != '0;
    assign head.item  = entries_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/btlv_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV parser back end
// Runs the tag, length and value state machine on one queued byte per cycle,
// unless the output register is stalled, and holds the result in that register.
// ----------------------------------------------------------------------------
module btlv_back #(
    parameter int MAX_TAG_BYTES = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  btlv_pkg::queue_head_t  head,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output btlv_pkg::result_t      out_result
);

    localparam int CNT_W = $clog2(MAX_TAG_BYTES + 1);

    btlv_pkg::phase_t   phase_reg, phase_next, phase_step;
    logic [31:0]        tag_shift_reg, tag_shift_next;
    logic [CNT_W-1:0]   tag_count_reg, tag_count_next;
    logic [15:0]        length_accum_reg, length_accum_next;
    logic [1:0]         length_left_reg, length_left_next;
    logic [15:0]        value_left_reg, value_left_next;
    logic               out_valid_reg;
    btlv_pkg::result_t  result_reg, result_next;

    btlv_pkg::item_t    it;
    logic               step;
    logic [15:0]        accum_shifted;
    logic [1:0]         left_dec;
    logic [15:0]        value_dec;
    logic [3:0]         count_wide;
    logic               done;
    logic               err;

    assign it            = head.item;
    assign step          = head.valid && (!out_valid_reg || out_ready);
    assign pop           = step;
    assign out_valid     = out_valid_reg;
    assign out_result    = result_reg;
    assign accum_shifted = {length_accum_reg[7:0], it.data_byte};
    assign left_dec      = (length_left_reg != 2'd0) ? length_left_reg - 2'd1 : 2'd0;
    assign value_dec     = (value_left_reg != 16'd0) ? value_left_reg - 16'd1 : 16'd0;

    always_comb begin
        phase_step = btlv_pkg::PH_TAG_FIRST;
        case (phase_reg)
            btlv_pkg::PH_TAG_LONG: begin
                if (tag_count_reg >= CNT_W'(MAX_TAG_BYTES)) begin
                    phase_step = btlv_pkg::PH_ERROR;
                end else begin
                    phase_step = it.more_bit ? btlv_pkg::PH_TAG_LONG
                                             : btlv_pkg::PH_LEN_FIRST;
                end
            end
            btlv_pkg::PH_LEN_FIRST: begin
                if (!it.more_bit) begin
                    phase_step = (it.data_byte == 8'd0) ? btlv_pkg::PH_TAG_FIRST
                                                        : btlv_pkg::PH_VALUE;
                end else if (it.len_one || it.len_two) begin
                    phase_step = btlv_pkg::PH_LEN_MORE;
                end else begin
                    phase_step = btlv_pkg::PH_ERROR;
                end
            end
            btlv_pkg::PH_LEN_MORE: begin
                if (left_dec != 2'd0) begin
                    phase_step = btlv_pkg::PH_LEN_MORE;
                end else begin
                    phase_step = (accum_shifted == 16'd0) ? btlv_pkg::PH_TAG_FIRST
                                                          : btlv_pkg::PH_VALUE;
                end
            end
            btlv_pkg::PH_VALUE: begin
                phase_step = (value_dec == 16'd0) ? btlv_pkg::PH_TAG_FIRST
                                                  : btlv_pkg::PH_VALUE;
            end
            btlv_pkg::PH_ERROR: begin
                phase_step = btlv_pkg::PH_ERROR;
            end
            default: begin
                phase_step = it.tag_long ? btlv_pkg::PH_TAG_LONG : btlv_pkg::PH_LEN_FIRST;
            end
        endcase
        phase_next = it.last_byte ? btlv_pkg::PH_TAG_FIRST : phase_step;
    end

    always_comb begin
        tag_shift_next    = tag_shift_reg;
        tag_count_next    = tag_count_reg;
        length_accum_next = length_accum_reg;
        length_left_next  = length_left_reg;
        value_left_next   = value_left_reg;
        done              = 1'b0;
        err               = 1'b0;
        result_next       = '0;
        result_next.byte_value = it.data_byte;
        result_next.byte_kind  = btlv_pkg::KIND_TAG;

        case (phase_reg)
            btlv_pkg::PH_TAG_LONG: begin
                if (tag_count_reg >= CNT_W'(MAX_TAG_BYTES)) begin
                    result_next.byte_kind = btlv_pkg::KIND_ERROR;
                    err = 1'b1;
                end else begin
                    tag_shift_next = {tag_shift_reg[23:0], it.data_byte};
                    tag_count_next = tag_count_reg + CNT_W'(1);
                end
            end
            btlv_pkg::PH_LEN_FIRST: begin
                result_next.byte_kind = btlv_pkg::KIND_LENGTH;
                if (!it.more_bit) begin
                    length_accum_next = {8'd0, it.data_byte};
                    result_next.decoded_length = {8'd0, it.data_byte};
                    if (it.data_byte == 8'd0) begin
                        done = 1'b1;
                    end else begin
                        value_left_next = {8'd0, it.data_byte};
                    end
                end else if (it.len_one) begin
                    length_accum_next = 16'd0;
                    length_left_next  = 2'd1;
                end else if (it.len_two) begin
                    length_accum_next = 16'd0;
                    length_left_next  = 2'd2;
                end else begin
                    result_next.byte_kind = btlv_pkg::KIND_ERROR;
                    err = 1'b1;
                end
            end
            btlv_pkg::PH_LEN_MORE: begin
                result_next.byte_kind = btlv_pkg::KIND_LENGTH;
                length_accum_next = accum_shifted;
                length_left_next  = left_dec;
                if (left_dec == 2'd0) begin
                    result_next.decoded_length = accum_shifted;
                    if (accum_shifted == 16'd0) begin
                        done = 1'b1;
                    end else begin
                        value_left_next = accum_shifted;
                    end
                end
            end
            btlv_pkg::PH_VALUE: begin
                result_next.byte_kind      = btlv_pkg::KIND_VALUE;
                result_next.decoded_length = length_accum_reg;
                result_next.value_offset   = length_accum_reg - value_left_reg;
                value_left_next = value_dec;
                done = value_dec == 16'd0;
            end
            btlv_pkg::PH_ERROR: begin
                result_next.byte_kind = btlv_pkg::KIND_IGNORED;
                err = 1'b1;
            end
            default: begin
                tag_shift_next    = {24'd0, it.data_byte};
                tag_count_next    = CNT_W'(1);
                length_accum_next = 16'd0;
                length_left_next  = 2'd0;
                value_left_next   = 16'd0;
            end
        endcase

        count_wide = 4'(tag_count_next);
        if (done) begin
            result_next.record_done = 1'b1;
            result_next.tag_bits    = tag_shift_next;
            result_next.tag_bytes   = (count_wide > 4'd4) ? 3'd4 : count_wide[2:0];
        end

        if (it.last_byte) begin
            if (err || phase_step == btlv_pkg::PH_ERROR) begin
                result_next.end_status = btlv_pkg::END_ERROR;
            end else if (phase_step == btlv_pkg::PH_TAG_FIRST) begin
                result_next.end_status = btlv_pkg::END_CLEAN;
            end else begin
                result_next.end_status = btlv_pkg::END_TRUNCATED;
            end
            tag_shift_next    = 32'd0;
            tag_count_next    = '0;
            length_accum_next = 16'd0;
            length_left_next  = 2'd0;
            value_left_next   = 16'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= btlv_pkg::PH_TAG_FIRST;
            tag_shift_reg    <= 32'd0;
            tag_count_reg    <= '0;
            length_accum_reg <= 16'd0;
            length_left_reg  <= 2'd0;
            value_left_reg   <= 16'd0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (step) begin
                phase_reg        <= phase_next;
                tag_shift_reg    <= tag_shift_next;
                tag_count_reg    <= tag_count_next;
                length_accum_reg <= length_accum_next;
                length_left_reg  <= length_left_next;
                value_left_reg   <= value_left_next;
                out_valid_reg    <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg    <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            result_reg <= result_next;
        end
    end

endmodule

/* rtl/ber_tlv_stream_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BER-TLV stream parser
// Classifies each byte of a BER-TLV buffer as tag, length, value, error or
// ignored and reports record completion and end-of-buffer status.
// ----------------------------------------------------------------------------
// The parser takes one byte per cycle and gives one result item per byte, so
// it sustains one item per clock cycle when the output side is ready. A byte
// is written into the four-entry queue behind the front end when it is
// accepted and is registered in the output register of the parser state
// machine when it leaves the queue; the state update sets the rate. The
// queue lets the input keep flowing for up to four items while the output
// is stalled.
// ----------------------------------------------------------------------------
module ber_tlv_stream_parser #(
    parameter int MAX_TAG_BYTES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [btlv_pkg::TDATA_W-1:0] m_axis_tdata,
    // [7:0] byte_value, [23:8] decoded_length, [39:24] value_offset,
    // [71:40] tag_bits, [74:72] tag_bytes, [76:75] end_status, rest zero
    output logic [2:0]  m_axis_tuser,   // [2:0] byte_kind
    output logic        m_axis_tlast    // record_done
);

    logic                   queue_full;
    logic                   queue_push;
    btlv_pkg::item_t        queue_item;
    logic                   queue_pop;
    btlv_pkg::queue_head_t  queue_head;
    btlv_pkg::result_t      result;

    btlv_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .queue_full    (queue_full),
        .queue_push    (queue_push),
        .queue_item    (queue_item)
    );

    btlv_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (queue_push),
        .push_item (queue_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .head      (queue_head)
    );

    btlv_back #(
        .MAX_TAG_BYTES (MAX_TAG_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (queue_head),
        .pop        (queue_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_result (result)
    );

    assign m_axis_tuser = result.byte_kind;
    assign m_axis_tlast = result.record_done;
    assign m_axis_tdata = {3'd0, result.end_status, result.tag_bytes, result.tag_bits,
                           result.value_offset, result.decoded_length, result.byte_value};

endmodule
